// ===== rtl/core/obeg_pkg.sv =====
// obeg_pkg: shared constants and the edge table for the box edge generator.
// No dependencies. Used by oriented_box_edge_generator and obeg_checker.
package obeg_pkg;

  localparam int NUM_LANES   = 9;   // one divider lane per rotation matrix entry
  localparam int NUM_AXES    = 3;
  localparam int NUM_CORNERS = 8;
  localparam int DIV_CYCLES  = 16;  // two quotient bits per cycle, 32 bits
  localparam int SUM_W       = 49;  // centre plus offset, wide enough for any coord width

  localparam logic [4:0] LAST_INDEX = 5'd23;
  localparam logic signed [15:0] QUAT_ONE = 16'sd16384;

  // Corner visited at each line list position, edges 0-1 0-2 0-4 1-3 1-5 2-3
  // 2-6 3-7 4-6 4-5 5-7 6-7.
  function automatic logic [2:0] edge_corner(input logic [4:0] idx);
    logic [2:0] c;
    unique case (idx)
      5'd0:  c = 3'd0;
      5'd1:  c = 3'd1;
      5'd2:  c = 3'd0;
      5'd3:  c = 3'd2;
      5'd4:  c = 3'd0;
      5'd5:  c = 3'd4;
      5'd6:  c = 3'd1;
      5'd7:  c = 3'd3;
      5'd8:  c = 3'd1;
      5'd9:  c = 3'd5;
      5'd10: c = 3'd2;
      5'd11: c = 3'd3;
      5'd12: c = 3'd2;
      5'd13: c = 3'd6;
      5'd14: c = 3'd3;
      5'd15: c = 3'd7;
      5'd16: c = 3'd4;
      5'd17: c = 3'd6;
      5'd18: c = 3'd4;
      5'd19: c = 3'd5;
      5'd20: c = 3'd5;
      5'd21: c = 3'd7;
      5'd22: c = 3'd6;
      default: c = 3'd7;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/oriented_box_edge_generator.sv =====
// oriented_box_edge_generator: box size, centre and quaternion in, 24 line list points out.
// Depends on obeg_pkg. Checked by obeg_checker (bound from its own file).
//
//   channel | handshake            | word
//   --------+----------------------+---------------------------------------------
//   in      | in_valid / in_stall  | size_x..z, centre_x..z, quat_w..z
//   out     | out_valid / out_stall| point_x..z, point_index, last_point
//
// Flow: four front stages (capture, quaternion products, matrix and norm,
// matrix times size) feed nine divider lanes that retire two quotient bits a
// cycle. Eight corners then leave one a cycle, while the bank being written is
// free, through a two stage round/offset pipe into one of two corner banks. A
// new box enters the divider only once the last one has issued all its corners;
// the 24 points of a box are read out from a full bank.
// Reset: synchronous, clears all valid bits, counters and bank flags.
// Stalls: out_stall holds the output word; the front stages back up into
// in_stall. The corner banks need no reset.
module oriented_box_edge_generator import obeg_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [30:0]        size_x,
  input  logic [30:0]        size_y,
  input  logic [30:0]        size_z,
  input  logic signed [31:0] centre_x,
  input  logic signed [31:0] centre_y,
  input  logic signed [31:0] centre_z,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z,
  output logic [4:0]         point_index,
  output logic               last_point
);

  localparam logic signed [SUM_W-1:0] SAT_HI =
    SUM_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  // ---------------------------------------------------------------- stage 0
  logic               s0_valid;
  logic [30:0]        s0_size [NUM_AXES];
  logic signed [31:0] s0_centre [NUM_AXES];
  logic signed [15:0] s0_qw, s0_qx, s0_qy, s0_qz;

  // ---------------------------------------------------------------- stage 1
  logic               s1_valid;
  logic [30:0]        s1_size [NUM_AXES];
  logic signed [31:0] s1_centre [NUM_AXES];
  logic signed [31:0] p_ww, p_xx, p_yy, p_zz, p_xy, p_wz, p_xz, p_wy, p_yz, p_wx;

  // ---------------------------------------------------------------- stage 2
  logic               s2_valid;
  logic [30:0]        s2_size [NUM_AXES];
  logic signed [31:0] s2_centre [NUM_AXES];
  logic [32:0]        s2_mag [NUM_LANES];
  logic               s2_neg [NUM_LANES];
  logic [33:0]        s2_d;

  // ---------------------------------------------------------------- stage 3
  logic               s3_valid;
  logic signed [31:0] s3_centre [NUM_AXES];
  logic [63:0]        s3_prod [NUM_LANES];
  logic               s3_neg [NUM_LANES];
  logic [33:0]        s3_d;
  logic [35:0]        s3_d3;
  logic [36:0]        s3_d5;

  // ---------------------------------------------------------------- divider
  logic               div_busy, div_done;
  logic [3:0]         div_cnt;
  logic [33:0]        rem [NUM_LANES];
  logic [31:0]        qr [NUM_LANES];
  logic [33:0]        rem_next [NUM_LANES];
  logic [31:0]        qr_next [NUM_LANES];
  logic               dv_neg [NUM_LANES];
  logic signed [31:0] dv_centre [NUM_AXES];
  logic [33:0]        dv_d;
  logic [35:0]        dv_d3;
  logic [36:0]        dv_d5;
  logic               div_load;

  // ---------------------------------------------------------------- corner pipe
  logic [2:0]         seq_cnt;
  logic               wr_bank;
  logic               issue;
  logic               a_valid;
  logic [2:0]         a_corner;
  logic               a_bank;
  logic signed [34:0] a_q [NUM_AXES];
  logic signed [36:0] a_r [NUM_AXES];
  logic signed [31:0] a_centre [NUM_AXES];
  logic [33:0]        a_d;
  logic [35:0]        a_d3;
  logic [36:0]        a_d5;
  logic signed [34:0] q_sum [NUM_AXES];
  logic signed [36:0] r_sum [NUM_AXES];
  logic               b_valid;
  logic [2:0]         b_corner;
  logic               b_bank;
  logic signed [35:0] b_res [NUM_AXES];
  logic signed [31:0] b_centre [NUM_AXES];
  logic signed [35:0] res_next [NUM_AXES];
  logic signed [31:0] coord [NUM_AXES];

  // ---------------------------------------------------------------- banks, output
  logic [31:0]        mem_x [2*NUM_CORNERS];
  logic [31:0]        mem_y [2*NUM_CORNERS];
  logic [31:0]        mem_z [2*NUM_CORNERS];
  logic [1:0]         bank_full;
  logic [1:0]         bank_clr;
  logic [1:0]         bank_set;
  logic               rd_bank;
  logic [4:0]         pt;
  logic               out_load;
  logic [3:0]         rd_addr;

  logic s0_ready, s1_ready, s2_ready, s3_ready;

  // Front pipe backpressure: a stage moves when the next one is empty or moving.
  assign div_load = s3_valid && !div_busy && !div_done;
  assign s3_ready = !s3_valid || div_load;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign s0_ready = !s0_valid || s1_ready;
  assign in_stall = !s0_ready;

  // Stage 0: capture, a zero quaternion becomes the identity.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_ready) begin
      s0_valid <= in_valid;
    end
    if (s0_ready && in_valid) begin
      s0_size[0]   <= size_x;
      s0_size[1]   <= size_y;
      s0_size[2]   <= size_z;
      s0_centre[0] <= centre_x;
      s0_centre[1] <= centre_y;
      s0_centre[2] <= centre_z;
      s0_qx <= quat_x;
      s0_qy <= quat_y;
      s0_qz <= quat_z;
      if (quat_w == '0 && quat_x == '0 && quat_y == '0 && quat_z == '0) begin
        s0_qw <= QUAT_ONE;
      end else begin
        s0_qw <= quat_w;
      end
    end
  end

  // Stage 1: the ten quaternion products.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= s0_valid;
    end
    if (s1_ready && s0_valid) begin
      s1_size   <= s0_size;
      s1_centre <= s0_centre;
      p_ww <= s0_qw * s0_qw;
      p_xx <= s0_qx * s0_qx;
      p_yy <= s0_qy * s0_qy;
      p_zz <= s0_qz * s0_qz;
      p_xy <= s0_qx * s0_qy;
      p_wz <= s0_qw * s0_qz;
      p_xz <= s0_qx * s0_qz;
      p_wy <= s0_qw * s0_qy;
      p_yz <= s0_qy * s0_qz;
      p_wx <= s0_qw * s0_qx;
    end
  end

  // Stage 2: matrix scaled by the squared norm, kept as magnitude and sign.
  logic signed [33:0] m_ent [NUM_LANES];
  logic [32:0]        n_sq;

  always_comb begin
    m_ent[0] = 34'(p_ww) + 34'(p_xx) - 34'(p_yy) - 34'(p_zz);
    m_ent[1] = (34'(p_xy) - 34'(p_wz)) <<< 1;
    m_ent[2] = (34'(p_xz) + 34'(p_wy)) <<< 1;
    m_ent[3] = (34'(p_xy) + 34'(p_wz)) <<< 1;
    m_ent[4] = 34'(p_ww) - 34'(p_xx) + 34'(p_yy) - 34'(p_zz);
    m_ent[5] = (34'(p_yz) - 34'(p_wx)) <<< 1;
    m_ent[6] = (34'(p_xz) - 34'(p_wy)) <<< 1;
    m_ent[7] = (34'(p_yz) + 34'(p_wx)) <<< 1;
    m_ent[8] = 34'(p_ww) - 34'(p_xx) - 34'(p_yy) + 34'(p_zz);
    n_sq = 33'(unsigned'(p_ww)) + 33'(unsigned'(p_xx))
         + 33'(unsigned'(p_yy)) + 33'(unsigned'(p_zz));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      s2_size   <= s1_size;
      s2_centre <= s1_centre;
      s2_d      <= {n_sq, 1'b0};
      for (int k = 0; k < NUM_LANES; k++) begin
        s2_neg[k] <= m_ent[k][33];
        s2_mag[k] <= m_ent[k][33] ? 33'(-m_ent[k]) : m_ent[k][32:0];
      end
    end
  end

  // Stage 3: each |matrix entry| times the size of its column.
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
    if (s3_ready && s2_valid) begin
      s3_centre <= s2_centre;
      s3_neg    <= s2_neg;
      s3_d      <= s2_d;
      s3_d3     <= 36'(s2_d) + {1'b0, s2_d, 1'b0};
      s3_d5     <= 37'(s2_d) + {1'b0, s2_d, 2'b00};
      for (int k = 0; k < NUM_LANES; k++) begin
        s3_prod[k] <= 64'(s2_mag[k]) * 64'(s2_size[k % NUM_AXES]);
      end
    end
  end

  // Divider lanes: restoring division, two steps per cycle. Each quotient
  // is below 2^30, so the high dividend half seeds the remainder.
  always_comb begin
    logic [34:0] t;
    logic [33:0] ra;
    logic [31:0] qa;
    for (int k = 0; k < NUM_LANES; k++) begin
      ra = rem[k];
      qa = qr[k];
      for (int s = 0; s < 2; s++) begin
        t = {ra, qa[31]};
        if (t >= {1'b0, dv_d}) begin
          ra = 34'(t - {1'b0, dv_d});
          qa = {qa[30:0], 1'b1};
        end else begin
          ra = t[33:0];
          qa = {qa[30:0], 1'b0};
        end
      end
      rem_next[k] = ra;
      qr_next[k]  = qa;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
      div_cnt  <= '0;
    end else if (div_load) begin
      div_busy <= 1'b1;
      div_cnt  <= '0;
    end else if (div_busy) begin
      div_cnt <= div_cnt + 4'd1;
      if (div_cnt == 4'(DIV_CYCLES - 1)) begin
        div_busy <= 1'b0;
        div_done <= 1'b1;
      end
    end else if (issue && seq_cnt == 3'(NUM_CORNERS - 1)) begin
      div_done <= 1'b0;
    end
    if (div_load) begin
      dv_neg    <= s3_neg;
      dv_centre <= s3_centre;
      dv_d      <= s3_d;
      dv_d3     <= s3_d3;
      dv_d5     <= s3_d5;
      for (int k = 0; k < NUM_LANES; k++) begin
        rem[k] <= {2'b00, s3_prod[k][63:32]};
        qr[k]  <= s3_prod[k][31:0];
      end
    end else if (div_busy) begin
      rem <= rem_next;
      qr  <= qr_next;
    end
  end

  // Corner stage A: signed sums of quotients and remainders for this corner.
  assign issue = div_done && !bank_full[wr_bank];

  always_comb begin
    logic sgn;
    for (int i = 0; i < NUM_AXES; i++) begin
      q_sum[i] = '0;
      r_sum[i] = '0;
      for (int j = 0; j < NUM_AXES; j++) begin
        // corner bits: x half negative for c >= 4, y for odd c, z for c mod 4 >= 2
        unique case (j)
          0:       sgn = seq_cnt[2];
          1:       sgn = seq_cnt[0];
          default: sgn = seq_cnt[1];
        endcase
        sgn = sgn ^ dv_neg[i*NUM_AXES + j];
        if (sgn) begin
          q_sum[i] = q_sum[i] - $signed({3'b000, qr[i*NUM_AXES + j]});
          r_sum[i] = r_sum[i] - $signed({3'b000, rem[i*NUM_AXES + j]});
        end else begin
          q_sum[i] = q_sum[i] + $signed({3'b000, qr[i*NUM_AXES + j]});
          r_sum[i] = r_sum[i] + $signed({3'b000, rem[i*NUM_AXES + j]});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      seq_cnt <= '0;
      wr_bank <= 1'b0;
    end else begin
      a_valid <= issue;
      if (issue) begin
        seq_cnt <= seq_cnt + 3'd1;
        if (seq_cnt == 3'(NUM_CORNERS - 1)) begin
          wr_bank <= !wr_bank;
        end
      end
    end
    if (issue) begin
      a_corner <= seq_cnt;
      a_bank   <= wr_bank;
      a_q      <= q_sum;
      a_r      <= r_sum;
      a_centre <= dv_centre;
      a_d      <= dv_d;
      a_d3     <= dv_d3;
      a_d5     <= dv_d5;
    end
  end

  // Corner stage B: value is Q + R/d with |R| < 3d. Round R/d to nearest,
  // ties away from zero of the whole value, by comparing 2R with odd
  // multiples m*d; a tie rounds up when Q >= (1-m)/2.
  always_comb begin
    logic signed [37:0] tw;
    logic signed [37:0] thr;
    logic signed [34:0] qlim;
    logic [2:0]         cnt;
    logic               up;
    for (int i = 0; i < NUM_AXES; i++) begin
      tw  = {a_r[i], 1'b0};
      cnt = '0;
      for (int j = 0; j < 6; j++) begin
        unique case (j)
          0:       thr = -$signed({1'b0, a_d5});
          1:       thr = -$signed({2'b00, a_d3});
          2:       thr = -$signed({4'b0000, a_d});
          3:       thr = $signed({4'b0000, a_d});
          4:       thr = $signed({2'b00, a_d3});
          default: thr = $signed({1'b0, a_d5});
        endcase
        qlim = 35'(3 - j);
        up   = (a_q[i] >= qlim) ? (tw >= thr) : (tw > thr);
        cnt  = cnt + 3'(up);
      end
      res_next[i] = 36'(a_q[i]) + $signed({33'd0, cnt}) - 36'sd3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    if (a_valid) begin
      b_corner <= a_corner;
      b_bank   <= a_bank;
      b_res    <= res_next;
      b_centre <= a_centre;
    end
  end

  // Corner stage C: add centre, saturate, write the bank.
  always_comb begin
    logic signed [SUM_W-1:0] sum;
    for (int i = 0; i < NUM_AXES; i++) begin
      sum = SUM_W'(b_centre[i]) + SUM_W'(b_res[i]);
      if (sum > SAT_HI) begin
        sum = SAT_HI;
      end else if (sum < SAT_LO) begin
        sum = SAT_LO;
      end
      coord[i] = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      mem_x[{b_bank, b_corner}] <= coord[0];
      mem_y[{b_bank, b_corner}] <= coord[1];
      mem_z[{b_bank, b_corner}] <= coord[2];
    end
  end

  // Output: walk the line list over a full bank, one point per word.
  assign out_load = bank_full[rd_bank] && (!out_valid || !out_stall);
  assign rd_addr  = {rd_bank, edge_corner(pt)};

  // the writer only fills a bank the reader is not draining
  assign bank_clr = (out_load && pt == LAST_INDEX) ? (2'b01 << rd_bank) : 2'b00;
  assign bank_set = (b_valid && b_corner == 3'(NUM_CORNERS - 1)) ? (2'b01 << b_bank) : 2'b00;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_full <= '0;
      rd_bank   <= 1'b0;
      pt        <= '0;
      out_valid <= 1'b0;
    end else begin
      bank_full <= (bank_full & ~bank_clr) | bank_set;
      if (out_load) begin
        out_valid <= 1'b1;
        if (pt == LAST_INDEX) begin
          pt <= '0;
          rd_bank <= !rd_bank;
        end else begin
          pt <= pt + 5'd1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (out_load) begin
      point_x     <= mem_x[rd_addr];
      point_y     <= mem_y[rd_addr];
      point_z     <= mem_z[rd_addr];
      point_index <= pt;
      last_point  <= (pt == LAST_INDEX);
    end
  end

endmodule

// ===== rtl/core/obeg_checker.sv =====
// obeg_checker: port level checks on the box edge generator output channel.
// Depends on obeg_pkg; bound to oriented_box_edge_generator at the end of this file.
module obeg_checker import obeg_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] point_x,
  input logic signed [31:0] point_y,
  input logic signed [31:0] point_z,
  input logic [4:0]         point_index,
  input logic               last_point
);

  // held word stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(point_x) && $stable(point_y)
      && $stable(point_z) && $stable(point_index) && $stable(last_point))
    else $error("output word changed under stall");

  // last marker tracks the final list position
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_point == (point_index == LAST_INDEX)))
    else $error("last_point mismatch");

  // taken word that is not the last one is followed by its successor
  a_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_point ##1 out_valid
      |-> point_index == $past(point_index) + 5'd1)
    else $error("point_index out of sequence");

  // reset leaves no word on the output
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind oriented_box_edge_generator obeg_checker u_obeg_checker (.*);
